>>> hdl/controller_line_command_parser_defines.svh
// Assertion macros shared by the line command parser modules.
`ifndef CONTROLLER_LINE_COMMAND_PARSER_DEFINES_SVH
`define CONTROLLER_LINE_COMMAND_PARSER_DEFINES_SVH

// Property checked on every rising clk edge, off while rst_n is low.
`define CLCP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true on a clock edge.
`define CLCP_NEVER(label, cond, msg) \
    `CLCP_ASSERT(label, !(cond), msg)

`endif

>>> hdl/clcp_pkg.sv
// Types, constants and helper functions of the line command parser.
package clcp_pkg;

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SP  = 8'h20;

    // word_match codes: 0..2 letters matched, 3 full "end", 4 no match
    localparam logic [2:0] MATCH_FULL = 3'd3;
    localparam logic [2:0] MATCH_NONE = 3'd4;

    localparam logic [11:0] STICK_NEUTRAL = 12'h800;
    localparam logic [7:0]  HAT_MAX       = 8'd8;

    localparam int BTN_W   = 18;
    localparam int STICK_W = 12;

    typedef enum logic [1:0] {
        ST_APPLIED = 2'd0,
        ST_NEUTRAL = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    // Summary of one finished line, handed from the front to the back.
    typedef struct packed {
        logic        drop;
        logic [2:0]  count;
        logic [2:0]  match;
        logic        hex_err;
        logic [15:0] wire_word;
        logic [7:0]  hat;
        logic [7:0]  lx;
        logic [7:0]  ly;
        logic [7:0]  rx;
        logic [7:0]  ry;
    } line_desc_t;

    // {valid, value} of a hex character
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    // letters of the word "end"
    function automatic logic [7:0] end_letter(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'h65;
            2'd1:    r = 8'h6E;
            default: r = 8'h64;
        endcase
        return r;
    endfunction

    // hat code to direction bits (up, right, down, left at bits 14-17)
    function automatic logic [BTN_W-1:0] hat_bits(input logic [3:0] hat);
        logic [BTN_W-1:0] r;
        case (hat)
            4'd0:    r = 18'h04000;
            4'd1:    r = 18'h0C000;
            4'd2:    r = 18'h08000;
            4'd3:    r = 18'h18000;
            4'd4:    r = 18'h10000;
            4'd5:    r = 18'h30000;
            4'd6:    r = 18'h20000;
            4'd7:    r = 18'h24000;
            default: r = 18'h00000;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/clcp_front.sv
// Front end: per-character lexer that builds a line summary.
module clcp_front
    import clcp_pkg::*;
#(
    parameter int LINE_MAX = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] rx_byte,
    output logic       q_push,
    output line_desc_t q_desc
);

    localparam int LW = $clog2(LINE_MAX + 1);

    logic [LW-1:0] len_reg, len_next;
    logic          drop_reg, drop_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic          in_tok_reg, in_tok_next;
    logic          herr_reg, herr_next;
    logic [2:0]    match_reg, match_next;
    logic [15:0]   wire_reg, wire_next;
    logic [7:0]    vals_reg [5];
    logic [7:0]    vals_next [5];

    logic       is_lf;
    logic       is_sep;
    logic [4:0] hd;
    logic [2:0] cnt_new;

    assign is_lf  = (rx_byte == CH_LF);
    assign is_sep = (rx_byte == CH_SP) || (rx_byte == CH_TAB) || (rx_byte == CH_CR);
    assign hd     = hex_digit(rx_byte);
    assign cnt_new = (!in_tok_reg && cnt_reg != 3'd7) ? cnt_reg + 3'd1 : cnt_reg;

    always_comb
    begin
        len_next    = len_reg;
        drop_next   = drop_reg;
        cnt_next    = cnt_reg;
        in_tok_next = in_tok_reg;
        herr_next   = herr_reg;
        match_next  = match_reg;
        wire_next   = wire_reg;
        for (int i = 0; i < 5; i++)
        begin
            vals_next[i] = vals_reg[i];
        end
        if (take)
        begin
            if (is_lf)
            begin
                len_next    = '0;
                drop_next   = 1'b0;
                cnt_next    = 3'd0;
                in_tok_next = 1'b0;
                herr_next   = 1'b0;
                match_next  = 3'd0;
                wire_next   = 16'd0;
                for (int i = 0; i < 5; i++)
                begin
                    vals_next[i] = 8'd0;
                end
            end
            else if (drop_reg)
            begin
                drop_next = 1'b1;
            end
            else if (len_reg >= LW'(LINE_MAX))
            begin
                drop_next = 1'b1;
            end
            else
            begin
                len_next = len_reg + LW'(1);
                if (is_sep)
                begin
                    in_tok_next = 1'b0;
                end
                else
                begin
                    in_tok_next = 1'b1;
                    cnt_next    = cnt_new;
                    if (cnt_new == 3'd1)
                    begin
                        if (match_reg < MATCH_FULL &&
                            (rx_byte | 8'h20) == end_letter(match_reg[1:0]))
                            match_next = match_reg + 3'd1;
                        else
                            match_next = MATCH_NONE;
                        // wire word limited to 16 bits
                        if (!hd[4] || wire_reg[15:12] != 4'd0)
                            herr_next = 1'b1;
                        else
                            wire_next = {wire_reg[11:0], hd[3:0]};
                    end
                    for (int i = 0; i < 5; i++)
                    begin
                        if (cnt_new == 3'(i + 2))
                        begin
                            if (!hd[4] || vals_reg[i][7:4] != 4'd0)
                                herr_next = 1'b1;
                            else
                                vals_next[i] = {vals_reg[i][3:0], hd[3:0]};
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            drop_reg   <= 1'b0;
            cnt_reg    <= 3'd0;
            in_tok_reg <= 1'b0;
            herr_reg   <= 1'b0;
            match_reg  <= 3'd0;
            wire_reg   <= 16'd0;
            for (int i = 0; i < 5; i++)
            begin
                vals_reg[i] <= 8'd0;
            end
        end
        else
        begin
            len_reg    <= len_next;
            drop_reg   <= drop_next;
            cnt_reg    <= cnt_next;
            in_tok_reg <= in_tok_next;
            herr_reg   <= herr_next;
            match_reg  <= match_next;
            wire_reg   <= wire_next;
            for (int i = 0; i < 5; i++)
            begin
                vals_reg[i] <= vals_next[i];
            end
        end
    end

    assign q_push            = take && is_lf;
    assign q_desc.drop       = drop_reg;
    assign q_desc.count      = cnt_reg;
    assign q_desc.match      = match_reg;
    assign q_desc.hex_err    = herr_reg;
    assign q_desc.wire_word  = wire_reg;
    assign q_desc.hat        = vals_reg[0];
    assign q_desc.lx         = vals_reg[1];
    assign q_desc.ly         = vals_reg[2];
    assign q_desc.rx         = vals_reg[3];
    assign q_desc.ry         = vals_reg[4];

endmodule

>>> hdl/clcp_queue.sv
// Short queue of line summaries between front and back.
`include "controller_line_command_parser_defines.svh"
module clcp_queue
    import clcp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  line_desc_t wdata,
    input  logic       pop,
    output line_desc_t rdata,
    output logic       q_full,
    output logic       q_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    line_desc_t    mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign q_full  = (count_reg == CW'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign rdata   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            if (push && !pop)
                count_reg <= count_reg + CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CW'(1);
        end
    end

    `CLCP_ASSERT(a_count_bound, count_reg <= CW'(DEPTH), "queue count above depth")
    `CLCP_NEVER(a_no_overflow, push && !pop && q_full, "write into full queue")
    `CLCP_NEVER(a_no_underflow, pop && q_empty, "read from empty queue")

endmodule

>>> hdl/clcp_back.sv
// Back end: applies a line summary to the pad state and holds the result.
`include "controller_line_command_parser_defines.svh"
module clcp_back
    import clcp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  line_desc_t         q_desc,
    output logic               q_pop,
    input  logic               pop,
    output logic               res_valid,
    output status_t            res_status,
    output logic [BTN_W-1:0]   btn,
    output logic [STICK_W-1:0] lx,
    output logic [STICK_W-1:0] ly,
    output logic [STICK_W-1:0] rx,
    output logic [STICK_W-1:0] ry
);

    logic               valid_reg;
    status_t            status_reg, status_next;
    logic [BTN_W-1:0]   btn_reg, btn_next;
    logic [STICK_W-1:0] lx_reg, lx_next, ly_reg, ly_next;
    logic [STICK_W-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic               count_ok;
    logic               take;

    assign take  = !q_empty && (!valid_reg || pop);
    assign q_pop = take;

    assign count_ok = (q_desc.count == 3'd2) || (q_desc.count == 3'd4) ||
                      (q_desc.count == 3'd6);

    always_comb
    begin
        status_next = ST_IGNORED;
        btn_next    = btn_reg;
        lx_next     = lx_reg;
        ly_next     = ly_reg;
        rx_next     = rx_reg;
        ry_next     = ry_reg;
        if (q_desc.drop || q_desc.count == 3'd0)
        begin
            status_next = ST_IGNORED;
        end
        else if (q_desc.count == 3'd1)
        begin
            if (q_desc.match == MATCH_FULL)
            begin
                status_next = ST_NEUTRAL;
                btn_next    = '0;
                lx_next     = STICK_NEUTRAL;
                ly_next     = STICK_NEUTRAL;
                rx_next     = STICK_NEUTRAL;
                ry_next     = STICK_NEUTRAL;
            end
        end
        else if (count_ok && !q_desc.hex_err && q_desc.hat <= HAT_MAX)
        begin
            status_next = ST_APPLIED;
            btn_next    = {4'd0, q_desc.wire_word[15:2]} | hat_bits(q_desc.hat[3:0]);
            if (q_desc.wire_word[1])
            begin
                lx_next = {q_desc.lx, 4'd0};
                ly_next = {q_desc.ly, 4'd0};
            end
            // right stick follows the left-stick fields on four-field lines
            if (q_desc.wire_word[0])
            begin
                if (q_desc.count == 3'd6)
                begin
                    rx_next = {q_desc.rx, 4'd0};
                    ry_next = {q_desc.ry, 4'd0};
                end
                else if (q_desc.count == 3'd4)
                begin
                    rx_next = {q_desc.lx, 4'd0};
                    ry_next = {q_desc.ly, 4'd0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            status_reg <= ST_IGNORED;
            btn_reg    <= '0;
            lx_reg     <= STICK_NEUTRAL;
            ly_reg     <= STICK_NEUTRAL;
            rx_reg     <= STICK_NEUTRAL;
            ry_reg     <= STICK_NEUTRAL;
        end
        else
        begin
            if (take)
            begin
                valid_reg  <= 1'b1;
                status_reg <= status_next;
                btn_reg    <= btn_next;
                lx_reg     <= lx_next;
                ly_reg     <= ly_next;
                rx_reg     <= rx_next;
                ry_reg     <= ry_next;
            end
            else if (pop)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid  = valid_reg;
    assign res_status = status_reg;
    assign btn        = btn_reg;
    assign lx         = lx_reg;
    assign ly         = ly_reg;
    assign rx         = rx_reg;
    assign ry         = ry_reg;

    `CLCP_ASSERT(a_neutral_pad,
        valid_reg && status_reg == ST_NEUTRAL |->
            btn_reg == '0 && lx_reg == STICK_NEUTRAL && ry_reg == STICK_NEUTRAL,
        "neutral result with pad not neutral")
    `CLCP_ASSERT(a_ignore_holds,
        take && status_next == ST_IGNORED |=>
            $stable(btn_reg) && $stable(lx_reg) && $stable(ry_reg),
        "ignored line changed pad")
    `CLCP_ASSERT(a_left_held,
        take && status_next == ST_APPLIED && !q_desc.wire_word[1] |=>
            $stable(lx_reg) && $stable(ly_reg),
        "left stick moved without its flag")

endmodule

>>> hdl/controller_line_command_parser.sv
// Top level of the serial line command parser for a game pad.
// Throughput: one character per cycle while the result side keeps draining.
// A newline's summary enters the line queue, then the result register when free.
// The line queue depth (QUEUE_DEPTH) sets how many finished lines may wait.
// Reset: async active-low; pad neutral (buttons 0, sticks 2048), queue empty.
module controller_line_command_parser
    import clcp_pkg::*;
#(
    parameter int LINE_MAX    = 64,
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    // character side
    input  logic               push,
    output logic               full,
    input  logic [7:0]         rx_byte,
    // result side
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         status,
    output logic [BTN_W-1:0]   buttons,
    output logic [STICK_W-1:0] left_x,
    output logic [STICK_W-1:0] left_y,
    output logic [STICK_W-1:0] right_x,
    output logic [STICK_W-1:0] right_y
);

    // An input transaction completes on push while the line queue has room.
    logic       take;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    line_desc_t q_wdata;
    line_desc_t q_rdata;
    logic       res_valid;
    status_t    res_status;

    assign take = push && !full;
    assign full = q_full;

    // Front: lexes each character and on a newline pushes the line summary.
    clcp_front #(
        .LINE_MAX (LINE_MAX)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx_byte),
        .q_push  (q_push),
        .q_desc  (q_wdata)
    );

    // Queue decouples the lexer from the pad update / result register.
    clcp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    // Back: evaluates a summary, updates the pad and holds the result
    // until the result transaction completes.
    clcp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_desc     (q_rdata),
        .q_pop      (q_pop),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_status (res_status),
        .btn        (buttons),
        .lx         (left_x),
        .ly         (left_y),
        .rx         (right_x),
        .ry         (right_y)
    );

    assign empty  = !res_valid;
    assign status = res_status;

endmodule
